// ----- rtl/core/gcode_line_extractor_defines.svh -----
// assertion macros for the gcode line extractor
`ifndef GCODE_LINE_EXTRACTOR_DEFINES_SVH
`define GCODE_LINE_EXTRACTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/gle_pkg.sv -----
// shared types and character codes for the gcode line extractor
package gle_pkg;

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_T    = 8'h54;

    typedef struct packed {
        logic accept_byte;
        logic rd_issue;
        logic load_byte;
        logic load_nl;
    } t_dp_cmd;

    typedef struct packed {
        logic is_newline;
        logic has_bytes;
        logic rd_done;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/core/gle_ram.sv -----
// generic single-write single-read ram with registered read
module gle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/gle_ctrl.sv -----
// controller: accepts bytes and sequences the line drain
module gle_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gle_pkg::t_dp_status i_status,
    output gle_pkg::t_dp_cmd    o_cmd
);

    import gle_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;
    localparam logic [1:0] ST_LAST = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.accept_byte = accept;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_status.is_newline && i_status.has_bytes) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_WR;
            end
            ST_WR: begin
                if (i_status.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    n_state         = i_status.rd_done ? ST_LAST : ST_RD;
                end
            end
            ST_LAST: begin
                if (i_status.out_free) begin
                    o_cmd.load_nl = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/gle_dpath.sv -----
// datapath: line flags, kept count, line store and output register
`include "gcode_line_extractor_defines.svh"

module gle_dpath #(
    parameter int DEPTH = 62
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_in_byte,
    input  gle_pkg::t_dp_cmd    i_cmd,
    output gle_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_last_of_line
);

    import gle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic          r_in_comment;
    logic          n_in_comment;
    logic          r_awaiting;
    logic          n_awaiting;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_rd_ptr;
    logic [CW-1:0] n_rd_ptr;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [7:0]    r_out_byte;
    logic [7:0]    n_out_byte;
    logic          r_out_last;
    logic          n_out_last;
    logic          wr_en;
    logic [7:0]    rd_data;
    logic          is_cmd_letter;
    logic          out_free;

    assign is_cmd_letter = (i_in_byte == CH_G) || (i_in_byte == CH_M) || (i_in_byte == CH_T);
    assign out_free      = !r_out_valid || !i_out_stall;

    assign o_status.is_newline = (i_in_byte == CH_NL);
    assign o_status.has_bytes  = (r_count != '0);
    assign o_status.rd_done    = (r_rd_ptr == r_count);
    assign o_status.out_free   = out_free;

    // byte filter, store read pointer and kept-count clear
    always_comb begin
        n_in_comment = r_in_comment;
        n_awaiting   = r_awaiting;
        n_count      = r_count;
        n_rd_ptr     = r_rd_ptr;
        wr_en        = 1'b0;
        if (i_cmd.accept_byte) begin
            if (i_in_byte == CH_NL) begin
                n_in_comment = 1'b0;
                n_awaiting   = 1'b1;
                n_rd_ptr     = '0;
            end else if (r_count != DEPTH_C) begin
                if (i_in_byte == CH_SEMI) begin
                    n_in_comment = 1'b1;
                end else begin
                    n_awaiting = r_awaiting && !is_cmd_letter;
                    if (!r_in_comment && !n_awaiting && (i_in_byte != CH_CR)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + ONE_C;
                    end
                end
            end
        end
        if (i_cmd.rd_issue) begin
            n_rd_ptr = r_rd_ptr + ONE_C;
        end
        if (i_cmd.load_nl) begin
            n_count = '0;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.load_byte) begin
            n_out_valid = 1'b1;
            n_out_byte  = rd_data;
            n_out_last  = 1'b0;
        end else if (i_cmd.load_nl) begin
            n_out_valid = 1'b1;
            n_out_byte  = CH_NL;
            n_out_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment <= 1'b0;
            r_awaiting   <= 1'b1;
            r_count      <= '0;
            r_rd_ptr     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_in_comment <= n_in_comment;
            r_awaiting   <= n_awaiting;
            r_count      <= n_count;
            r_rd_ptr     <= n_rd_ptr;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    gle_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_in_byte),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_rd_ptr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last_of_line = r_out_last;

    `GLE_ASSERT_NOW(a_count_in_range, 1'b1, r_count <= DEPTH_C, "kept count beyond store depth")
    `GLE_ASSERT_NOW(a_read_below_count, i_cmd.rd_issue, r_rd_ptr < r_count, "store read past kept count")
    `GLE_ASSERT_NOW(a_last_is_newline, r_out_valid && r_out_last, r_out_byte == CH_NL, "last beat not newline")
    `GLE_ASSERT_NEXT(a_load_byte_valid, i_cmd.load_byte, r_out_valid && !r_out_last, "byte beat not presented")

endmodule

// ----- rtl/core/gcode_line_extractor.sv -----
// G-code line extractor: one raw file byte per input beat in, command-line bytes out.
// Bytes ahead of the first G, M or T of a line are skipped, a semicolon drops the rest
// of the line, and carriage returns are dropped. Kept bytes go to a line store of
// LINE_CHARS-2 entries; once it is full, all bytes but newline are ignored. A newline
// ending a line with N kept bytes emits those N bytes and then a newline beat with
// o_last_of_line set. Input takes one byte per cycle while filtering; after a newline
// that ends a nonempty line the input stalls until each stored byte has had a store
// read and an output register load and the closing newline is loaded, waiting out any
// output stall. Empty lines emit nothing.
module gcode_line_extractor #(
    parameter int LINE_CHARS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_line
);

    import gle_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    gle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gle_dpath #(
        .DEPTH (LINE_CHARS - 2)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_byte      (i_in_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_line (o_last_of_line)
    );

endmodule
